// ----- rtl/core/nns_pkg.sv -----
`default_nettype none

package nns_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned LIDX_W  = 16;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned SRC_W   = 9;
  localparam int unsigned DST_W   = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CADDR_W = 2;
  // Product of a coordinate and a source side, and the quotient width.
  localparam int unsigned PROD_W  = COORD_W + SRC_W;
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned CNT_W   = $clog2(QUOT_W);
  localparam int unsigned RIDX_W  = 16;

  localparam logic [SRC_W-1:0] SRC_SIDE_MAX = SRC_W'(256);
  localparam logic [SRC_W-1:0] SRC_RESET    = SRC_W'(256);
  localparam logic [DST_W-1:0] DST_RESET    = DST_W'(256);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CADDR_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CADDR_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CADDR_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CADDR_W-1:0] REG_DST_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV,
    ST_INDEX,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic latch;
    logic div_init;
    logic div_step;
    logic index;
    logic read;
  } dp_cmd_t;

  function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
    logic [SRC_W-1:0] r;
    if (v == '0) begin
      r = SRC_W'(1);
    end else if (v > SRC_SIDE_MAX) begin
      r = SRC_SIDE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nearest_neighbor_image_scaler.sv -----
`default_nettype none

// Nearest-neighbour scaler over a frame store of MAX_PIXELS 32-bit source
// pixels. A load item (cmd 0) writes its pixel on the edge that accepts it and
// the block stays free, so loads go in at one per cycle while busy is low. A
// fetch item (cmd 1) holds busy until its result has been delivered, and the
// next item is accepted once busy drops. The coordinate products are formed
// and loaded into the two shared-step dividers, which then settle the quotients
// (one quotient bit per cycle, for the column and the row in parallel); then
// the raster index is formed and the frame store is read. The result appears
// on pixel_o and out_of_range_o for the single cycle in which valid_o is high,
// and must be taken then. Size registers may only be written while busy is low.
module nearest_neighbor_image_scaler #(
  parameter int unsigned MAX_PIXELS   = 65536,
  parameter int unsigned MAX_DST_SIDE = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         cmd_i,
  input  wire logic [nns_pkg::LIDX_W-1:0]   load_index_i,
  input  wire logic [nns_pkg::PIX_W-1:0]    load_pixel_i,
  input  wire logic [nns_pkg::COORD_W-1:0]  dst_x_i,
  input  wire logic [nns_pkg::COORD_W-1:0]  dst_y_i,
  output logic                              valid_o,
  output logic      [nns_pkg::PIX_W-1:0]    pixel_o,
  output logic                              out_of_range_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [nns_pkg::CADDR_W-1:0]  cfg_addr_i,
  input  wire logic [nns_pkg::CFG_W-1:0]    cfg_data_i
);
  import nns_pkg::*;

  dp_cmd_t dp_cmd;

  nns_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (valid_o),
    .cmd_o  (dp_cmd)
  );

  nns_datapath #(
    .MAX_PIXELS   (MAX_PIXELS),
    .MAX_DST_SIDE (MAX_DST_SIDE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .load_index_i   (load_index_i),
    .load_pixel_i   (load_pixel_i),
    .dst_x_i        (dst_x_i),
    .dst_y_i        (dst_y_i),
    .pixel_o        (pixel_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/nns_div.sv -----
`default_nettype none

module nns_div (
  input  wire logic                      clk_i,
  input  wire logic                      init_i,
  input  wire logic                      step_i,
  input  wire logic [nns_pkg::PROD_W-1:0] num_i,
  input  wire logic [nns_pkg::DST_W-1:0]  den_i,
  output logic      [nns_pkg::QUOT_W-1:0] quot_o,
  output logic      [nns_pkg::PROD_W-1:0] rem_o
);
  import nns_pkg::*;

  logic [PROD_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0] den_q, den_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic              ge;

  // The quotient is known to stay below 256, so the divisor starts shifted
  // up by seven places and one quotient bit is settled per step.
  always_comb begin
    ge     = (rem_q >= den_q);
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (init_i) begin
      rem_d  = num_i;
      den_d  = PROD_W'(den_i) << (QUOT_W - 1);
      quot_d = '0;
    end else if (step_i) begin
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      quot_d = {quot_q[QUOT_W-2:0], ge};
      den_d  = den_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/nns_ctrl.sv -----
`default_nettype none

module nns_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic             cmd_i,
  output logic                  busy,
  output logic                  done_o,
  output nns_pkg::dp_cmd_t      cmd_o
);
  import nns_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             idle;

  assign idle = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start && cmd_i == CMD_FETCH) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: state_d = ST_READ;
      ST_READ:  state_d = ST_RESP;
      ST_RESP:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = idle && start && (cmd_i == CMD_LOAD);
    cmd_o.latch    = idle && start && (cmd_i == CMD_FETCH);
    cmd_o.div_init = (state_q == ST_PROD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.index    = (state_q == ST_INDEX);
    cmd_o.read     = (state_q == ST_READ);
    busy           = !idle;
    done_o         = (state_q == ST_RESP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_fetch_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |-> ##12 done_o)
    else $error("fetch result not delivered after the fixed latency");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after delivering a result");

  a_index_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.index |-> ($past(cmd_o.div_step) && $past(cnt_q) == CNT_W'(QUOT_W - 1)))
    else $error("index computed before the division finished");

endmodule

`default_nettype wire

// ----- rtl/core/nns_datapath.sv -----
`default_nettype none

module nns_datapath #(
  parameter int unsigned MAX_PIXELS   = 65536,
  parameter int unsigned MAX_DST_SIDE = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire nns_pkg::dp_cmd_t             cmd_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [nns_pkg::CADDR_W-1:0]  cfg_addr_i,
  input  wire logic [nns_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic [nns_pkg::LIDX_W-1:0]   load_index_i,
  input  wire logic [nns_pkg::PIX_W-1:0]    load_pixel_i,
  input  wire logic [nns_pkg::COORD_W-1:0]  dst_x_i,
  input  wire logic [nns_pkg::COORD_W-1:0]  dst_y_i,
  output logic      [nns_pkg::PIX_W-1:0]    pixel_o,
  output logic                              out_of_range_o
);
  import nns_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PIXELS);

  logic [SRC_W-1:0]   src_w_q, src_h_q;
  logic [DST_W-1:0]   dst_w_q, dst_h_q;
  logic [SRC_W-1:0]   sw, sh;
  logic [DST_W-1:0]   dw, dh;

  logic [COORD_W-1:0] x_q, y_q;
  logic               oor_q;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic [QUOT_W-1:0]  sx, sy;
  logic [PROD_W-1:0]  rem_x, rem_y;
  logic [RIDX_W-1:0]  idx_q;
  logic [31:0]        idx_ext, load_ext;
  logic               idx_ok;
  logic               ok_q;
  logic [PIX_W-1:0]   rd_q;
  logic [PIX_W-1:0]   mem [MAX_PIXELS];

  function automatic logic [DST_W-1:0] clamp_dst(input logic [DST_W-1:0] v);
    logic [DST_W-1:0] r;
    if (v == '0) begin
      r = DST_W'(1);
    end else if (32'(v) > 32'(MAX_DST_SIDE)) begin
      r = DST_W'(MAX_DST_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_RESET;
      src_h_q <= SRC_RESET;
      dst_w_q <= DST_RESET;
      dst_h_q <= DST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i[SRC_W-1:0];
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i[SRC_W-1:0];
        REG_DST_WIDTH:  dst_w_q <= cfg_data_i[DST_W-1:0];
        REG_DST_HEIGHT: dst_h_q <= cfg_data_i[DST_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw = clamp_src(src_w_q);
  assign sh = clamp_src(src_h_q);
  assign dw = clamp_dst(dst_w_q);
  assign dh = clamp_dst(dst_h_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      x_q   <= dst_x_i;
      y_q   <= dst_y_i;
      oor_q <= (DST_W'(dst_x_i) >= dw) || (DST_W'(dst_y_i) >= dh);
    end
  end

  assign prod_x = PROD_W'(x_q) * PROD_W'(sw);
  assign prod_y = PROD_W'(y_q) * PROD_W'(sh);

  nns_div u_div_x (
    .clk_i  (clk_i),
    .init_i (cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .num_i  (prod_x),
    .den_i  (dw),
    .quot_o (sx),
    .rem_o  (rem_x)
  );

  nns_div u_div_y (
    .clk_i  (clk_i),
    .init_i (cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .num_i  (prod_y),
    .den_i  (dh),
    .quot_o (sy),
    .rem_o  (rem_y)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.index) begin
      idx_q <= RIDX_W'(RIDX_W'(sy) * RIDX_W'(sw)) + RIDX_W'(sx);
    end
  end

  assign idx_ext  = 32'(idx_q);
  assign load_ext = 32'(load_index_i);
  assign idx_ok   = (idx_ext < 32'(MAX_PIXELS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ext < 32'(MAX_PIXELS)) begin
      mem[load_ext[AW-1:0]] <= load_pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      ok_q <= idx_ok;
      if (idx_ok) begin
        rd_q <= mem[idx_ext[AW-1:0]];
      end
    end
  end

  assign pixel_o        = (oor_q || !ok_q) ? '0 : rd_q;
  assign out_of_range_o = oor_q;

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.index && !oor_q) |-> (SRC_W'(sx) < sw) && (SRC_W'(sy) < sh))
    else $error("source coordinate beyond the source size");

  // Outside the destination the quotient can overflow, so only inside fetches count.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.index && !oor_q) |-> (rem_x < PROD_W'(dw)) && (rem_y < PROD_W'(dh)))
    else $error("division left a remainder not below the divisor");

  a_coord_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.index && !oor_q) |-> (DST_W'(x_q) < dw) && (DST_W'(y_q) < dh))
    else $error("fetch treated as inside although it lies outside");

endmodule

`default_nettype wire
